FILE: design/smce_pkg.sv
`default_nettype none

package smce_pkg;

    localparam int NSAMP      = 8;
    localparam int IDX_W      = 3;
    localparam int ACC_W      = 18;
    localparam int SHIFT_BITS = 3;
    localparam int EST_W      = 16;
    localparam int OUT_WIDTH  = 16;

    localparam longint OUT_MAX = (64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1;
    localparam longint OUT_MIN = -OUT_MAX - 64'sd1;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [EST_W-1:0] est_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [NSAMP-1:0]        sign_row_t;

    // bit k of row j set: sample k is added into sum j, else subtracted
    localparam sign_row_t SIGN_MAT [NSAMP] = '{
        8'b00101101,
        8'b01001011,
        8'b10000111,
        8'b00011110,
        8'b11011101,
        8'b10111011,
        8'b01110111,
        8'b11101110
    };

    localparam idx_t LAST_IDX = idx_t'(NSAMP - 1);

    // handoff from the accumulator bank to the output stage
    typedef struct packed {
        logic load;
        logic keep;
    } blk_ctl_t;

    // saturating add or subtract on the accumulator width
    function automatic acc_t acc_step(input acc_t acc, input acc_t x, input logic add);
        logic signed [ACC_W:0] sum;
        acc_t                  res;
        if (add) begin
            sum = {acc[ACC_W-1], acc} + {x[ACC_W-1], x};
        end else begin
            sum = {acc[ACC_W-1], acc} - {x[ACC_W-1], x};
        end
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = sum[ACC_W-1:0];
        end
        return res;
    endfunction

    // optional negate (no clamp, one extra bit), floor shift, clamp, cut to field width
    function automatic est_t finish(input acc_t sum, input logic keep);
        logic signed [ACC_W:0]            v;
        logic signed [ACC_W-SHIFT_BITS:0] sh;
        longint                           sv;
        v  = keep ? {sum[ACC_W-1], sum} : -{sum[ACC_W-1], sum};
        sh = v[ACC_W:SHIFT_BITS];
        sv = longint'(sh);
        if (sv > OUT_MAX) begin
            sv = OUT_MAX;
        end else if (sv < OUT_MIN) begin
            sv = OUT_MIN;
        end
        return sv[EST_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/smce_accum.sv
`default_nettype none

module smce_accum (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire smce_pkg::acc_t       x_re,
    input  wire smce_pkg::acc_t       x_im,
    input  wire logic                 keep,
    input  wire logic                 drain_busy,
    output smce_pkg::blk_ctl_t        ctl,
    output smce_pkg::acc_t            sum_re [smce_pkg::NSAMP],
    output smce_pkg::acc_t            sum_im [smce_pkg::NSAMP]
);
    import smce_pkg::*;

    acc_t acc_re_reg  [NSAMP];
    acc_t acc_im_reg  [NSAMP];
    acc_t acc_re_next [NSAMP];
    acc_t acc_im_next [NSAMP];
    idx_t count_reg;
    logic accept;
    logic last_slot;

    assign last_slot = (count_reg == LAST_IDX);
    // the closing sample waits until the output stage has room for a block
    assign s_tready  = !(last_slot && drain_busy);
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        for (int j = 0; j < NSAMP; j++) begin
            acc_re_next[j] = acc_step(acc_re_reg[j], x_re, SIGN_MAT[j][count_reg]);
            acc_im_next[j] = acc_step(acc_im_reg[j], x_im, SIGN_MAT[j][count_reg]);
            sum_re[j]      = acc_re_next[j];
            sum_im[j]      = acc_im_next[j];
        end
        ctl.load = accept && last_slot;
        ctl.keep = keep;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int j = 0; j < NSAMP; j++) begin
                acc_re_reg[j] <= '0;
                acc_im_reg[j] <= '0;
            end
        end else if (accept) begin
            count_reg <= count_reg + idx_t'(1);
            for (int j = 0; j < NSAMP; j++) begin
                acc_re_reg[j] <= last_slot ? '0 : acc_re_next[j];
                acc_im_reg[j] <= last_slot ? '0 : acc_im_next[j];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/smce_drain.sv
`default_nettype none

module smce_drain (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire smce_pkg::blk_ctl_t   ctl,
    input  wire smce_pkg::acc_t       sum_re [smce_pkg::NSAMP],
    input  wire smce_pkg::acc_t       sum_im [smce_pkg::NSAMP],
    output logic                      busy,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output smce_pkg::est_t            est_re,
    output smce_pkg::est_t            est_im,
    output smce_pkg::idx_t            est_index,
    output logic                      est_last
);
    import smce_pkg::*;

    acc_t hold_re_reg [NSAMP];
    acc_t hold_im_reg [NSAMP];
    logic keep_reg;
    logic busy_reg;
    idx_t idx_reg;
    logic m_tvalid_reg;
    est_t est_re_reg;
    est_t est_im_reg;
    idx_t est_index_reg;
    logic est_last_reg;
    logic load_out;

    assign load_out = busy_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            for (int j = 0; j < NSAMP; j++) begin
                hold_re_reg[j] <= sum_re[j];
                hold_im_reg[j] <= sum_im[j];
            end
            keep_reg <= ctl.keep;
        end
        if (load_out) begin
            est_re_reg    <= finish(hold_re_reg[idx_reg], keep_reg);
            est_im_reg    <= finish(hold_im_reg[idx_reg], keep_reg);
            est_index_reg <= idx_reg;
            est_last_reg  <= (idx_reg == LAST_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= idx_reg + idx_t'(1);
                if (idx_reg == LAST_IDX) begin
                    busy_reg <= 1'b0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (ctl.load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
        end
    end

    assign busy      = busy_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign est_re    = est_re_reg;
    assign est_im    = est_im_reg;
    assign est_index = est_index_reg;
    assign est_last  = est_last_reg;

    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |-> !busy_reg)
        else $error("block handed over while previous block still draining");

    a_load_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> busy_reg && (idx_reg == '0))
        else $error("drain did not start at estimate zero");

    a_last_ends_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && (idx_reg == LAST_IDX) && !ctl.load |=> !busy_reg && m_tvalid_reg && est_last_reg)
        else $error("drain did not close on the last estimate");

    a_busy_only_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !ctl.load |=> $stable(idx_reg))
        else $error("estimate index moved while idle");

endmodule

`default_nettype wire

FILE: design/sign_matrix_channel_estimate_unit.sv
// Sign-matrix channel estimator.
// Input stream: one complex pre-estimate per word; eight words make a block.
// Each word updates all eight saturating accumulators in the cycle it is
// accepted, so samples are taken at one word per clock while s_tready is high.
// The flag on the eighth word of a block (s_tuser, 1 = keep sign, 0 = negate)
// selects the sign of the block's results.
// After the eighth word the sums move to a holding bank and the accumulators
// restart from zero; the bank then emits eight result words, index 0 to 7,
// m_tlast on index 7, one per cycle from a registered output while m_tready is high.
// Result path: the sums are registered into the holding bank when the eighth
// word is accepted, and each result word is then registered at the output.
// Throughput: one input word per cycle inside a block. The eighth word of a
// block is held off (s_tready low) while the previous block is still draining;
// at full input rate this holds off the eighth word of every block.
// A stalled receiver eventually stalls the input; nothing is dropped.
// Reset (aresetn low, synchronous) clears the accumulators, the sample
// position and any block waiting to drain.
`default_nettype none

module sign_matrix_channel_estimate_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // sample_re[17:0], sample_im[35:18], zero pad
    input  wire logic [0:0]  s_tuser,   // lts_first[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // est_re[15:0], est_im[31:16]
    output logic [2:0]       m_tuser,   // est_index[2:0]
    output logic             m_tlast    // est_last
);
    import smce_pkg::*;

    blk_ctl_t ctl;
    acc_t     sum_re [NSAMP];
    acc_t     sum_im [NSAMP];
    logic     drain_busy;
    est_t     est_re;
    est_t     est_im;
    idx_t     est_index;
    logic     est_last;

    smce_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .x_re       (s_tdata[17:0]),
        .x_im       (s_tdata[35:18]),
        .keep       (s_tuser[0]),
        .drain_busy (drain_busy),
        .ctl        (ctl),
        .sum_re     (sum_re),
        .sum_im     (sum_im)
    );

    smce_drain u_drain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sum_re    (sum_re),
        .sum_im    (sum_im),
        .busy      (drain_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .est_re    (est_re),
        .est_im    (est_im),
        .est_index (est_index),
        .est_last  (est_last)
    );

    assign m_tdata = {est_im, est_re};
    assign m_tuser = est_index;
    assign m_tlast = est_last;

endmodule

`default_nettype wire
